FILE: hw/rtl/tfr_pkg.sv
// Package for the telemetry frame receiver: frame constants, parse phase type
// and the completed-frame word passed from the parser to the result stage.
// No dependencies.
package tfr_pkg;

    // Frame framing bytes
    localparam logic [7:0] HDR1       = 8'hAA;
    localparam logic [7:0] HDR2       = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT = 8'hF1;
    localparam logic [7:0] FUNC_READ  = 8'h02;
    localparam logic [7:0] READ_ARG   = 8'h01;
    localparam logic [7:0] FUNC_SET   = 8'h10;
    localparam logic [7:0] ACK_FUNC   = 8'hEF;
    localparam logic [7:0] ACK_LEN    = 8'h02;

    // Fixed part of the acknowledge frame sum: AA AA EF 02
    localparam logic [7:0] ACK_BASE = 8'(32'(HDR1) + 32'(HDR1) + 32'(ACK_FUNC) + 32'(ACK_LEN));

    // Longest length byte accepted is MAX_LENGTH - 1 (range 13 to 64)
    localparam int unsigned MAX_LENGTH    = 50;
    localparam int unsigned KEPT_PAYLOAD  = 12;
    localparam int unsigned KEPT_IDX_W    = $clog2(KEPT_PAYLOAD);
    localparam int unsigned LEN_W         = 6;

    // Depth of the queue between parser and result stage
    localparam int unsigned FIFO_DEPTH    = 4;
    localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HUNT_HDR1 = 3'd0,
        PH_HUNT_HDR2 = 3'd1,
        PH_FUNC      = 3'd2,
        PH_LEN       = 3'd3,
        PH_PAYLOAD   = 3'd4,
        PH_CHECKSUM  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_BAD_SUM  = 2'd0,
        ST_PID_READ = 2'd1,
        ST_PID_SET  = 2'd2,
        ST_OTHER    = 2'd3
    } status_t;

    typedef logic [KEPT_PAYLOAD-1:0][7:0] payload_t;

    // One completed frame, classified
    typedef struct packed {
        status_t    status;
        logic [7:0] func;
        logic [7:0] sum;
        payload_t   payload;
    } frame_rec_t;

endpackage

FILE: hw/rtl/telemetry_frame_receiver.sv
// Top level of the telemetry frame receiver: parser, frame queue and result stage.
// Depends on tfr_pkg, tfr_parser, tfr_fifo and tfr_result.
//
// Usage: received serial bytes are written on rx_byte with push; a word is
// taken at a clock edge where push is high and full is low. One byte is taken
// per cycle while full is low, back to back. Frames are AA AF, function,
// length, payload and a checksum byte; every completed frame gives one result
// word, any other byte gives none. Results are read queue style: while empty
// is low the oldest result is on the result ports, and pop with empty low
// takes it. The edge that takes the checksum byte writes the four-deep frame
// queue, and the result moves from the queue into the output word at an edge
// where that word is free or being popped.
// Throughput: one byte per cycle while not full, set by the single-step parser.
// When the reader stalls, finished frames wait in the queue and the output
// word; full rises only when all four queue entries and the output word are
// occupied, and the parser then holds off further bytes.
// Reset clears the parser to header hunting, the kept payload to zero and
// empties the queue and the output word.
module telemetry_frame_receiver
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  logic               push,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         frame_status,
    output logic [7:0]         function_code,
    output logic [7:0]         frame_sum,
    output logic [7:0]         ack_checksum,
    output logic signed [15:0] inner_p_gain,
    output logic signed [15:0] inner_i_gain,
    output logic signed [15:0] inner_d_gain,
    output logic signed [15:0] outer_p_gain,
    output logic signed [15:0] outer_i_gain,
    output logic signed [15:0] outer_d_gain
);

    logic                byte_valid;
    logic                rec_push;
    tfr_pkg::frame_rec_t rec;
    tfr_pkg::frame_rec_t q_data;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;

    assign full       = q_full;
    assign byte_valid = push && !q_full;

    tfr_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .rec_push   (rec_push),
        .rec        (rec)
    );

    tfr_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    tfr_result u_result
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .frame_status  (frame_status),
        .function_code (function_code),
        .frame_sum     (frame_sum),
        .ack_checksum  (ack_checksum),
        .inner_p_gain  (inner_p_gain),
        .inner_i_gain  (inner_i_gain),
        .inner_d_gain  (inner_d_gain),
        .outer_p_gain  (outer_p_gain),
        .outer_i_gain  (outer_i_gain),
        .outer_d_gain  (outer_d_gain)
    );

endmodule

FILE: hw/rtl/tfr_parser.sv
// Front part of the telemetry frame receiver: byte-by-byte frame parser,
// running sum, kept payload bytes and frame classification.
// Depends on tfr_pkg.
module tfr_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic [7:0]         rx_byte,
    output logic               rec_push,
    output tfr_pkg::frame_rec_t rec
);

    tfr_pkg::phase_t          phase_reg, phase_next;
    logic [tfr_pkg::LEN_W-1:0] left_reg, left_next;
    logic [tfr_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]               sum_reg, sum_next;
    logic [7:0]               func_reg, func_next;
    tfr_pkg::payload_t        store_reg, store_next;
    logic                     store_wr;
    logic                     idx_kept;
    logic [tfr_pkg::KEPT_IDX_W-1:0] store_idx;

    assign idx_kept  = (idx_reg < tfr_pkg::LEN_W'(tfr_pkg::KEPT_PAYLOAD));
    assign store_idx = idx_reg[tfr_pkg::KEPT_IDX_W-1:0];

    // Advance the parse phase and the frame counters
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        func_next  = func_reg;
        if (byte_valid)
        begin
            case (phase_reg)
                tfr_pkg::PH_HUNT_HDR1:
                begin
                    if (rx_byte == tfr_pkg::HDR1)
                    begin
                        phase_next = tfr_pkg::PH_HUNT_HDR2;
                        sum_next   = rx_byte;
                    end
                end
                tfr_pkg::PH_HUNT_HDR2:
                begin
                    if (rx_byte == tfr_pkg::HDR2)
                    begin
                        phase_next = tfr_pkg::PH_FUNC;
                        sum_next   = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = tfr_pkg::PH_HUNT_HDR1;
                    end
                end
                tfr_pkg::PH_FUNC:
                begin
                    if (rx_byte != 8'd0 && rx_byte < tfr_pkg::FUNC_LIMIT)
                    begin
                        phase_next = tfr_pkg::PH_LEN;
                        func_next  = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = tfr_pkg::PH_HUNT_HDR1;
                    end
                end
                tfr_pkg::PH_LEN:
                begin
                    if (rx_byte < 8'(tfr_pkg::MAX_LENGTH))
                    begin
                        phase_next = tfr_pkg::PH_PAYLOAD;
                        left_next  = rx_byte[tfr_pkg::LEN_W-1:0];
                        idx_next   = '0;
                        sum_next   = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = tfr_pkg::PH_HUNT_HDR1;
                    end
                end
                tfr_pkg::PH_PAYLOAD:
                begin
                    if (left_reg != '0)
                    begin
                        idx_next  = idx_reg + 1'b1;
                        sum_next  = sum_reg + rx_byte;
                        left_next = left_reg - 1'b1;
                        if (left_reg == tfr_pkg::LEN_W'(1))
                        begin
                            phase_next = tfr_pkg::PH_CHECKSUM;
                        end
                    end
                    else
                    begin
                        // zero length never completes
                        phase_next = tfr_pkg::PH_HUNT_HDR1;
                    end
                end
                tfr_pkg::PH_CHECKSUM:
                begin
                    phase_next = tfr_pkg::PH_HUNT_HDR1;
                end
                default:
                begin
                    phase_next = tfr_pkg::PH_HUNT_HDR1;
                end
            endcase
        end
    end

    // Keep payload bytes; the checksum byte lands in the slot after a short payload
    always_comb
    begin
        store_wr = byte_valid && idx_kept &&
                   ((phase_reg == tfr_pkg::PH_PAYLOAD && left_reg != '0) ||
                    phase_reg == tfr_pkg::PH_CHECKSUM);
        store_next = store_reg;
        if (store_wr)
        begin
            store_next[store_idx] = rx_byte;
        end
    end

    // Classify the frame on its checksum byte
    always_comb
    begin
        rec_push    = byte_valid && (phase_reg == tfr_pkg::PH_CHECKSUM);
        rec.func    = func_reg;
        rec.sum     = sum_reg;
        rec.payload = store_next;
        if (rx_byte != sum_reg)
        begin
            rec.status = tfr_pkg::ST_BAD_SUM;
        end
        else if (func_reg == tfr_pkg::FUNC_READ && store_next[0] == tfr_pkg::READ_ARG)
        begin
            rec.status = tfr_pkg::ST_PID_READ;
        end
        else if (func_reg == tfr_pkg::FUNC_SET)
        begin
            rec.status = tfr_pkg::ST_PID_SET;
        end
        else
        begin
            rec.status = tfr_pkg::ST_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tfr_pkg::PH_HUNT_HDR1;
            left_reg  <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            func_reg  <= '0;
            store_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            func_reg  <= func_next;
            store_reg <= store_next;
        end
    end

endmodule

FILE: hw/rtl/tfr_fifo.sv
// Short queue of completed-frame words between the parser and the result stage.
// Depends on tfr_pkg.
module tfr_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  tfr_pkg::frame_rec_t wr_data,
    input  logic                rd_en,
    output tfr_pkg::frame_rec_t rd_data,
    output logic                full,
    output logic                empty
);

    tfr_pkg::frame_rec_t            mem_reg [tfr_pkg::FIFO_DEPTH];
    logic [tfr_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tfr_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tfr_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                           do_wr;
    logic                           do_rd;

    assign full    = (count_reg == tfr_pkg::FIFO_CNT_W'(tfr_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == tfr_pkg::FIFO_PTR_W'(tfr_pkg::FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == tfr_pkg::FIFO_PTR_W'(tfr_pkg::FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/tfr_result.sv
// Back part of the telemetry frame receiver: takes classified frames from the
// queue, forms the acknowledge checksum and holds the result word for the reader.
// Depends on tfr_pkg.
module tfr_result
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  tfr_pkg::frame_rec_t q_data,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          frame_status,
    output logic [7:0]          function_code,
    output logic [7:0]          frame_sum,
    output logic [7:0]          ack_checksum,
    output logic signed [15:0]  inner_p_gain,
    output logic signed [15:0]  inner_i_gain,
    output logic signed [15:0]  inner_d_gain,
    output logic signed [15:0]  outer_p_gain,
    output logic signed [15:0]  outer_i_gain,
    output logic signed [15:0]  outer_d_gain
);

    logic                valid_reg, valid_next;
    tfr_pkg::frame_rec_t rec_reg;
    logic [7:0]          ack_reg;
    logic                load;

    // Refill the output word when it is free or being taken
    assign load  = !q_empty && (!valid_reg || pop);
    assign q_pop = load;
    assign empty = !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= q_data;
            ack_reg <= tfr_pkg::ACK_BASE + q_data.func + q_data.sum;
        end
    end

    assign frame_status  = rec_reg.status;
    assign function_code = rec_reg.func;
    assign frame_sum     = rec_reg.sum;
    assign ack_checksum  = ack_reg;

    // Gains are big-endian byte pairs of the kept payload
    assign inner_p_gain = {rec_reg.payload[0],  rec_reg.payload[1]};
    assign inner_i_gain = {rec_reg.payload[2],  rec_reg.payload[3]};
    assign inner_d_gain = {rec_reg.payload[4],  rec_reg.payload[5]};
    assign outer_p_gain = {rec_reg.payload[6],  rec_reg.payload[7]};
    assign outer_i_gain = {rec_reg.payload[8],  rec_reg.payload[9]};
    assign outer_d_gain = {rec_reg.payload[10], rec_reg.payload[11]};

endmodule
